FILE: design/csd_pkg.sv
// Shared types and constants for the cyclic server dispatcher.
// Used by csd_ctrl, csd_datapath and cyclic_server_dispatcher_core.
`timescale 1ns / 1ps
`default_nettype none

package csd_pkg;

  localparam int MAX_SERVERS_DEF = 16;
  localparam int SLOT_LIMIT      = 16;

  localparam int TIME_W   = 32;
  localparam int BUSY_W   = 33;
  localparam int CNT_W    = 32;
  localparam int ID_W     = 4;
  localparam int NSRV_W   = 5;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_NUM_SERVERS = 1'b0;
  localparam logic [NSRV_W-1:0] NUM_SERVERS_RST = 5'd16;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_COMMIT,
    ST_SCAN,
    ST_LIST
  } state_t;

  typedef struct packed {
    logic accept;      // load request, clear scan state
    logic reduce_ptr;  // fold pointer below k
    logic pick;        // register chosen server
    logic commit;      // update server, emit request result
    logic scan_step;   // fold one count into the running max
    logic list_start;  // rewind cursor for listing
    logic emit;        // emit one report entry
    logic advance;     // step listing cursor
  } cmd_t;

  typedef struct packed {
    logic ptr_ge_k;
    logic cur_last_k;
    logic cur_match;
    logic cur_is_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/csd_ctrl.sv
// Controller state machine for the cyclic server dispatcher.
// Depends on csd_pkg; drives csd_datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
`default_nettype none

module csd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_action,
  output logic               in_ready,
  input  wire csd_pkg::sts_t sts,
  output csd_pkg::cmd_t      cmd
);
  import csd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = (in_action == KIND_REPORT) ? ST_SCAN : ST_PICK;
        end
      end
      ST_PICK: begin
        if (sts.ptr_ge_k) begin
          cmd.reduce_ptr = 1'b1;
        end else begin
          cmd.pick   = 1'b1;
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.accept = 1'b1;
            state_next = (in_action == KIND_REPORT) ? ST_SCAN : ST_PICK;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.cur_last_k) begin
          cmd.list_start = 1'b1;
          state_next     = ST_LIST;
        end
      end
      ST_LIST: begin
        if (sts.cur_match) begin
          if (sts.out_free) begin
            cmd.emit = 1'b1;
            if (sts.cur_is_last) begin
              state_next = ST_IDLE;
            end else begin
              cmd.advance = 1'b1;
            end
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/csd_datapath.sv
// Datapath of the cyclic server dispatcher: server table, free search,
// pointer, max scan and the output register. Depends on csd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csd_datapath #(
  parameter int MAX_SERVERS = csd_pkg::MAX_SERVERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire csd_pkg::cmd_t                 cmd,
  output csd_pkg::sts_t                      sts,
  input  wire logic [csd_pkg::NSRV_W-1:0]    num_servers,
  input  wire logic [csd_pkg::TIME_W-1:0]    arrival_time,
  input  wire logic [csd_pkg::TIME_W-1:0]    service_time,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_kind,
  output logic                               out_accepted,
  output logic [csd_pkg::ID_W-1:0]           out_server_id,
  output logic [csd_pkg::CNT_W-1:0]          out_count,
  output logic                               out_last
);
  import csd_pkg::*;

  localparam int SLOTS = (MAX_SERVERS < SLOT_LIMIT) ? MAX_SERVERS : SLOT_LIMIT;
  localparam int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KW    = $clog2(SLOTS + 1);

  logic [BUSY_W-1:0] busy_until   [SLOTS];
  logic [CNT_W-1:0]  served_count [SLOTS];

  logic [TIME_W-1:0] req_time;
  logic [TIME_W-1:0] req_svc;
  logic [IDXW-1:0]   ptr;
  logic [IDXW-1:0]   sel;
  logic              found;
  logic [CNT_W-1:0]  mx;
  logic [IDXW-1:0]   lastidx;

  logic [KW-1:0]     k;
  logic [SLOTS-1:0]  free_vec;
  logic [SLOTS-1:0]  hi_vec;
  logic [IDXW-1:0]   pick_idx;
  logic              pick_found;
  logic [CNT_W-1:0]  cnt_rd;
  logic [CNT_W-1:0]  cnt_inc;
  logic [IDXW-1:0]   ptr_next;

  function automatic logic [IDXW-1:0] first_set(input logic [SLOTS-1:0] v);
    logic [IDXW-1:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) r = IDXW'(i);
    end
    return r;
  endfunction

  // active server count: zero acts as one, clamp to the table size
  always_comb begin
    if (num_servers == '0) begin
      k = KW'(1);
    end else if (num_servers > NSRV_W'(SLOTS)) begin
      k = KW'(SLOTS);
    end else begin
      k = KW'(num_servers);
    end
  end

  // free servers and the cyclic first-free search from the pointer
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_vec[i] = (i < int'(k)) && (busy_until[i] <= {1'b0, req_time});
      hi_vec[i]   = free_vec[i] && (i >= int'(ptr));
    end
    pick_found = |free_vec;
    pick_idx   = (|hi_vec) ? first_set(hi_vec) : first_set(free_vec);
  end

  assign cnt_rd   = served_count[sel];
  assign cnt_inc  = (cnt_rd == '1) ? cnt_rd : cnt_rd + CNT_W'(1);
  assign ptr_next = (int'(ptr) + 1 >= int'(k)) ? '0 : ptr + IDXW'(1);

  always_comb begin
    sts.ptr_ge_k    = int'(ptr) >= int'(k);
    sts.cur_last_k  = int'(sel) == int'(k) - 1;
    sts.cur_match   = cnt_rd == mx;
    sts.cur_is_last = sel == lastidx;
    sts.out_free    = !out_valid || out_ready;
  end

  // server table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        busy_until[i]   <= '0;
        served_count[i] <= '0;
      end
    end else if (cmd.commit && found) begin
      busy_until[sel]   <= {1'b0, req_time} + {1'b0, req_svc};
      served_count[sel] <= cnt_inc;
    end
  end

  // pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.reduce_ptr) begin
      ptr <= ptr - IDXW'(k);
    end else if (cmd.commit) begin
      ptr <= ptr_next;
    end
  end

  // request operands, cursor and scan state
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_time <= arrival_time;
      req_svc  <= service_time;
    end
    if (cmd.accept || cmd.list_start) begin
      sel <= '0;
    end else if (cmd.pick) begin
      sel <= pick_idx;
    end else if (cmd.scan_step || cmd.advance) begin
      sel <= sel + IDXW'(1);
    end
    if (cmd.pick) begin
      found <= pick_found;
    end
    if (cmd.accept) begin
      mx      <= '0;
      lastidx <= '0;
    end else if (cmd.scan_step && (cnt_rd >= mx)) begin
      mx      <= cnt_rd;
      lastidx <= sel;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_kind      <= KIND_REQUEST;
      out_accepted  <= found;
      out_server_id <= found ? ID_W'(sel) : '0;
      out_count     <= found ? cnt_inc : '0;
      out_last      <= 1'b1;
    end else if (cmd.emit) begin
      out_kind      <= KIND_REPORT;
      out_accepted  <= 1'b0;
      out_server_id <= ID_W'(sel);
      out_count     <= mx;
      out_last      <= sts.cur_is_last;
    end
  end

`ifndef SYNTHESIS
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid && out_last && (out_kind == KIND_REQUEST))
    else $error("request commit did not leave a final request result");

  a_pick_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.pick && pick_found) |-> free_vec[pick_idx])
    else $error("picked server is not free");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit || cmd.emit) |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");
`endif

endmodule

`default_nettype wire

FILE: design/cyclic_server_dispatcher_core.sv
// Top level of the cyclic server dispatcher: stream ports, APB register,
// controller (csd_ctrl) and datapath (csd_datapath). Depends on csd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Dispatches requests over up to 16 servers in cyclic order. A request item
// (tuser = 0) frees every server whose busy-until time is at or before the
// arrival time, takes the first free server at or after the rotating start
// pointer and returns one result: accepted, server and its new handled count,
// or a drop. A report item (tuser = 1) returns every server whose count equals
// the maximum, in ascending order, with tlast on the final one. A request
// passes a free search state, then a table update state, and the next item
// is taken in the update cycle; the update cycle holds while the output
// register still carries an untaken result. After num_servers is lowered,
// the first request stays in the search state, lowering the pointer by k,
// until it lies below k. A report scans the first k servers for the maximum
// count, then lists servers in ascending order up to the last busiest one
// (at most k) through a single table read port, holding on output stalls;
// the next item is taken in the idle state after the final entry is loaded.
// The server table clears at reset. Write num_servers only while idle.
module cyclic_server_dispatcher_core #(
  parameter int MAX_SERVERS = csd_pkg::MAX_SERVERS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // stream in
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [31:0] arrival_time, [63:32] service_time
  input  wire logic [csd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] action
  input  wire logic                               s_axis_tuser,
  // stream out
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [0] accepted, [4:1] server_id, [36:5] handled_count, [39:37] zero
  output logic [csd_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  // [0] result_kind
  output logic                                    m_axis_tuser,
  output logic                                    m_axis_tlast,
  // APB register port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [csd_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [csd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [csd_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                    pready
);
  import csd_pkg::*;

  logic [NSRV_W-1:0] num_servers;
  cmd_t              cmd;
  sts_t              sts;
  logic              out_accepted;
  logic [ID_W-1:0]   out_server_id;
  logic [CNT_W-1:0]  out_count;

  // Register file: one register, num_servers; writes complete in the access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_servers <= NUM_SERVERS_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_NUM_SERVERS)) begin
      num_servers <= pwdata[NSRV_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_NUM_SERVERS) ?
                  {{(APB_DATA_W - NSRV_W){1'b0}}, num_servers} : '0;

  // Controller: sequences accept, search, update, scan and listing.
  csd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_action(s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: server table, pointer, scan state and the output register that
  // holds a finished result while the next request is taken.
  csd_datapath #(
    .MAX_SERVERS(MAX_SERVERS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .num_servers  (num_servers),
    .arrival_time (s_axis_tdata[TIME_W-1:0]),
    .service_time (s_axis_tdata[2*TIME_W-1:TIME_W]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_kind     (m_axis_tuser),
    .out_accepted (out_accepted),
    .out_server_id(out_server_id),
    .out_count    (out_count),
    .out_last     (m_axis_tlast)
  );

  // Pack the result: accepted, id, count from the low bit up, pad to bytes.
  assign m_axis_tdata = {{(OUT_TDATA_W - 1 - ID_W - CNT_W){1'b0}},
                         out_count, out_server_id, out_accepted};

endmodule

`default_nettype wire
